>>> hdl/ics_pkg.sv
// -----------------------------------------------------------------------------
// ics_pkg
// Shared types, sizes and constants of the category softmax block.
// -----------------------------------------------------------------------------
package ics_pkg;

	localparam int MAX_ITEMS      = 64;
	localparam int MAX_CATEGORIES = 8;
	localparam int MAX_DIMS       = 4;

	localparam int ITEM_W = 6;
	localparam int CAT_W  = 3;
	localparam int DIM_W  = 2;
	localparam int COEF_W = 16;
	localparam int NCAT_W = 4;
	localparam int NDIM_W = 3;

	localparam int SLOPE_DEPTH = MAX_ITEMS * MAX_CATEGORIES * MAX_DIMS;
	localparam int SLOPE_AW    = $clog2(SLOPE_DEPTH);
	localparam int OFF_DEPTH   = MAX_ITEMS * MAX_CATEGORIES;
	localparam int OFF_AW      = $clog2(OFF_DEPTH);

	localparam int ACC_W  = 35;
	localparam int EXP_W  = 32;
	localparam int PROB_W = 17;
	localparam int SUM_W  = 35;
	localparam int NUM_W  = 49;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int TERMS = 13;

	localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
	localparam logic [29:0]        LN2_Q30   = 30'd744261118;
	localparam logic signed [ACC_W-1:0] EXP_LIM = 35'sd201326592;

	typedef enum logic [1:0] {
		CMD_SLOPE   = 2'd0,
		CMD_OFFSET  = 2'd1,
		CMD_COMPUTE = 2'd2,
		CMD_NONE    = 2'd3
	} command_t;

	localparam logic REG_CATS = 1'b0;
	localparam logic REG_DIMS = 1'b1;

	typedef struct packed {
		logic [1:0]              command;
		logic [ITEM_W-1:0]       item;
		logic [CAT_W-1:0]        cat;
		logic [DIM_W-1:0]        dim;
		logic [COEF_W-1:0]       coef;
		logic [3:0][COEF_W-1:0]  ability;
		logic                    responded;
	} cmd_t;

	typedef struct packed {
		logic [NCAT_W-1:0] ncat;
		logic [NDIM_W-1:0] ndim;
	} cfg_t;

	// floor(2^32 / k), with k = 1 clipped to 32 bits
	function automatic logic [31:0] recip(input logic [3:0] k);
		logic [31:0] r;
		case (k)
			4'd1:    r = 32'hFFFF_FFFF;
			4'd2:    r = 32'h8000_0000;
			4'd3:    r = 32'h5555_5555;
			4'd4:    r = 32'h4000_0000;
			4'd5:    r = 32'h3333_3333;
			4'd6:    r = 32'h2AAA_AAAA;
			4'd7:    r = 32'h2492_4924;
			4'd8:    r = 32'h2000_0000;
			4'd9:    r = 32'h1C71_C71C;
			4'd10:   r = 32'h1999_9999;
			4'd11:   r = 32'h1745_D174;
			4'd12:   r = 32'h1555_5555;
			4'd13:   r = 32'h13B1_3B13;
			default: r = 32'h0000_0000;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/ics_front.sv
// -----------------------------------------------------------------------------
// ics_front
// Accepts requests, drops unknown commands and queues the rest.
// -----------------------------------------------------------------------------
module ics_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ics_pkg::cmd_t cmd_in,
	output logic          q_valid,
	output ics_pkg::cmd_t q_head,
	input  logic          q_pop
);

	ics_pkg::cmd_t                    queue_q [ics_pkg::QUEUE_DEPTH];
	logic [ics_pkg::QPTR_W-1:0]       wp_q;
	logic [ics_pkg::QPTR_W-1:0]       rp_q;
	logic [ics_pkg::QCNT_W-1:0]       cnt_q;
	logic                             push;
	logic                             pop;

	assign busy    = (cnt_q == ics_pkg::QCNT_W'(ics_pkg::QUEUE_DEPTH));
	assign push    = start && !busy && (cmd_in.command != ics_pkg::CMD_NONE);
	assign q_valid = (cnt_q != '0);
	assign pop     = q_pop && q_valid;
	assign q_head  = queue_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wp_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == ics_pkg::QPTR_W'(ics_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == ics_pkg::QPTR_W'(ics_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/ics_exp.sv
// -----------------------------------------------------------------------------
// ics_exp
// Multi-cycle fixed-point exp: Q11.24 in, saturating Q16.16 out.
// -----------------------------------------------------------------------------
module ics_exp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic signed [ics_pkg::ACC_W-1:0]  x,
	output logic                              done,
	output logic [ics_pkg::EXP_W-1:0]         result
);

	typedef enum logic [6:0] {
		E_IDLE  = 7'b0000001,
		E_RANGE = 7'b0000010,
		E_FRAC  = 7'b0000100,
		E_TMUL  = 7'b0001000,
		E_TREC  = 7'b0010000,
		E_TACC  = 7'b0100000,
		E_SHIFT = 7'b1000000
	} estate_t;

	estate_t                            state_q;
	logic signed [ics_pkg::ACC_W-1:0]   xr_q;
	logic signed [59:0]                 ym_q;
	logic [59:0]                        gm_q;
	logic signed [5:0]                  n_q;
	logic [30:0]                        term_q;
	logic [31:0]                        e_q;
	logic [3:0]                         k_q;
	logic [60:0]                        tp_q;
	logic [30:0]                        v_q;
	logic [62:0]                        vr_q;
	logic [30:0]                        q0;
	logic [30:0]                        rem;
	logic [30:0]                        qf;
	logic signed [6:0]                  s;
	logic [5:0]                         sh;
	logic [35:0]                        r36;

	always_comb begin
		q0  = vr_q[62:32];
		rem = v_q - 31'(q0 * k_q);
		qf  = (rem >= {27'd0, k_q}) ? q0 + 31'd1 : q0;
		s   = 7'(n_q) - 7'sd14;
		sh  = 6'(-s);
		if (!s[6]) begin
			r36 = {4'd0, e_q} << s[1:0];
		end else begin
			r36 = ({4'd0, e_q} + (36'd1 << (sh - 6'd1))) >> sh;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			E_IDLE: begin
				xr_q <= x;
			end
			E_RANGE: begin
				ym_q <= $signed(xr_q[28:0]) * ics_pkg::LOG2E_Q30;
			end
			E_FRAC: begin
				gm_q   <= ym_q[53:24] * ics_pkg::LN2_Q30;
				n_q    <= ym_q[59:54];
				term_q <= 31'h4000_0000;
				e_q    <= 32'h4000_0000;
				k_q    <= 4'd1;
			end
			E_TMUL: begin
				tp_q <= term_q * gm_q[59:30];
			end
			E_TREC: begin
				v_q  <= tp_q[60:30];
				vr_q <= tp_q[60:30] * ics_pkg::recip(k_q);
			end
			E_TACC: begin
				term_q <= qf;
				e_q    <= e_q + {1'b0, qf};
				k_q    <= k_q + 4'd1;
			end
			E_SHIFT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			done    <= 1'b0;
			result  <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				E_IDLE: begin
					if (go) state_q <= E_RANGE;
				end
				E_RANGE: begin
					if (xr_q >= ics_pkg::EXP_LIM) begin
						result  <= '1;
						done    <= 1'b1;
						state_q <= E_IDLE;
					end else if (xr_q <= -ics_pkg::EXP_LIM) begin
						result  <= '0;
						done    <= 1'b1;
						state_q <= E_IDLE;
					end else begin
						state_q <= E_FRAC;
					end
				end
				E_FRAC:  state_q <= E_TMUL;
				E_TMUL:  state_q <= E_TREC;
				E_TREC:  state_q <= E_TACC;
				E_TACC: begin
					state_q <= (k_q == 4'(ics_pkg::TERMS)) ? E_SHIFT : E_TMUL;
				end
				E_SHIFT: begin
					result  <= (r36[35:32] != 4'd0) ? '1 : r36[31:0];
					done    <= 1'b1;
					state_q <= E_IDLE;
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/ics_div.sv
// -----------------------------------------------------------------------------
// ics_div
// Bit-serial restoring divider, 17 quotient bits, one per cycle.
// -----------------------------------------------------------------------------
module ics_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [ics_pkg::NUM_W-1:0]     num,
	input  logic [ics_pkg::SUM_W-1:0]     den,
	output logic                          done,
	output logic [ics_pkg::PROB_W-1:0]    quot
);

	localparam int CNT_W = $clog2(ics_pkg::PROB_W + 1);

	logic                           run_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [ics_pkg::SUM_W-1:0]      rem_q;
	logic [ics_pkg::SUM_W-1:0]      den_q;
	logic [ics_pkg::PROB_W-1:0]     low_q;
	logic [ics_pkg::SUM_W:0]        trial;
	logic                           fits;

	assign trial = {rem_q, low_q[ics_pkg::PROB_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= ics_pkg::SUM_W'(num[ics_pkg::NUM_W-1:ics_pkg::PROB_W]);
			low_q <= num[ics_pkg::PROB_W-1:0];
			den_q <= den;
		end else if (run_q) begin
			rem_q <= fits ? ics_pkg::SUM_W'(trial - {1'b0, den_q})
			              : ics_pkg::SUM_W'(trial);
			low_q <= {low_q[ics_pkg::PROB_W-2:0], 1'b0};
			quot  <= {quot[ics_pkg::PROB_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(ics_pkg::PROB_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

endmodule

>>> hdl/ics_back.sv
// -----------------------------------------------------------------------------
// ics_back
// Table stores, dot product, exp and normalization sequencer.
// -----------------------------------------------------------------------------
module ics_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ics_pkg::cfg_t                 cfg,
	input  logic                          q_valid,
	input  ics_pkg::cmd_t                 q_head,
	output logic                          q_pop,
	output logic                          result_valid,
	output logic [ics_pkg::CAT_W-1:0]     category,
	output logic [ics_pkg::EXP_W-1:0]     exp_value,
	output logic [ics_pkg::PROB_W-1:0]    probability,
	output logic                          last
);

	typedef enum logic [6:0] {
		B_IDLE  = 7'b0000001,
		B_MAC   = 7'b0000010,
		B_EXPST = 7'b0000100,
		B_EXPW  = 7'b0001000,
		B_DIVST = 7'b0010000,
		B_DIVW  = 7'b0100000,
		B_EMIT  = 7'b1000000
	} bstate_t;

	bstate_t                                state_q;
	logic [ics_pkg::COEF_W-1:0]             slope_mem [ics_pkg::SLOPE_DEPTH];
	logic [ics_pkg::COEF_W-1:0]             offset_mem [ics_pkg::OFF_DEPTH];
	logic [ics_pkg::COEF_W-1:0]             slope_rd_q;
	logic [ics_pkg::COEF_W-1:0]             offset_rd_q;
	logic [ics_pkg::EXP_W-1:0]              ebuf_q [ics_pkg::MAX_CATEGORIES];

	logic [ics_pkg::ITEM_W-1:0]             item_q;
	logic [3:0][ics_pkg::COEF_W-1:0]        ab_q;
	logic [ics_pkg::NCAT_W-1:0]             ncat_q;
	logic [ics_pkg::NDIM_W-1:0]             ndim_q;
	logic [ics_pkg::CAT_W-1:0]              k_q;
	logic [ics_pkg::NDIM_W-1:0]             j_q;
	logic [ics_pkg::SUM_W-1:0]              sum_q;
	logic signed [ics_pkg::ACC_W-1:0]       acc_q;
	logic [ics_pkg::PROB_W-1:0]             p_q;

	logic                                   v_s1, first_s1, last_s1;
	logic [ics_pkg::DIM_W-1:0]              d_s1;
	logic                                   v_s2, first_s2, last_s2;
	logic signed [31:0]                     prod_s2;
	logic [ics_pkg::COEF_W-1:0]             off_s2;

	logic [ics_pkg::NCAT_W-1:0]             ncat_sat;
	logic [ics_pkg::NDIM_W-1:0]             ndim_sat;
	logic [ics_pkg::CAT_W-1:0]              last_k;
	logic                                   take;
	logic                                   issue;
	logic                                   exp_go, exp_done;
	logic [ics_pkg::EXP_W-1:0]              exp_res;
	logic                                   div_go, div_done;
	logic [ics_pkg::PROB_W-1:0]             div_q;
	logic [ics_pkg::NUM_W-1:0]              div_num;

	always_comb begin
		if (cfg.ncat == '0) begin
			ncat_sat = ics_pkg::NCAT_W'(1);
		end else if (cfg.ncat > ics_pkg::NCAT_W'(ics_pkg::MAX_CATEGORIES)) begin
			ncat_sat = ics_pkg::NCAT_W'(ics_pkg::MAX_CATEGORIES);
		end else begin
			ncat_sat = cfg.ncat;
		end
		if (cfg.ndim == '0) begin
			ndim_sat = ics_pkg::NDIM_W'(1);
		end else if (cfg.ndim > ics_pkg::NDIM_W'(ics_pkg::MAX_DIMS)) begin
			ndim_sat = ics_pkg::NDIM_W'(ics_pkg::MAX_DIMS);
		end else begin
			ndim_sat = cfg.ndim;
		end
	end

	assign last_k  = ics_pkg::CAT_W'(ncat_q - 1'b1);
	assign take    = (state_q == B_IDLE) && q_valid;
	assign q_pop   = take;
	assign issue   = (state_q == B_MAC) && (j_q < ndim_q);
	assign exp_go  = (state_q == B_EXPST);
	assign div_go  = (state_q == B_DIVST) && (sum_q != '0);
	assign div_num = {1'b0, ebuf_q[k_q], 16'd0} + {14'd0, sum_q[ics_pkg::SUM_W-1:1]};

	assign result_valid = (state_q == B_EMIT);
	assign category     = k_q;
	assign exp_value    = ebuf_q[k_q];
	assign probability  = p_q;
	assign last         = (k_q == last_k);

	// coefficient stores: written from the queue head, read during the dot product
	always_ff @(posedge clk) begin
		if (take && q_head.command == ics_pkg::CMD_SLOPE) begin
			slope_mem[{q_head.item, q_head.cat, q_head.dim}] <= q_head.coef;
		end
		slope_rd_q <= slope_mem[{item_q, k_q, j_q[ics_pkg::DIM_W-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (take && q_head.command == ics_pkg::CMD_OFFSET) begin
			offset_mem[{q_head.item, q_head.cat}] <= q_head.coef;
		end
		offset_rd_q <= offset_mem[{item_q, k_q}];
	end

	// payload of the multiply stages
	always_ff @(posedge clk) begin
		d_s1     <= j_q[ics_pkg::DIM_W-1:0];
		first_s1 <= (j_q == '0);
		last_s1  <= (j_q == ndim_q - 1'b1);
		prod_s2  <= $signed(slope_rd_q) * $signed(ab_q[d_s1]);
		off_s2   <= offset_rd_q;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		if (v_s2) begin
			acc_q <= (first_s2 ? {{(ics_pkg::ACC_W-28){off_s2[15]}}, off_s2, 12'd0} : acc_q)
			       + {{(ics_pkg::ACC_W-32){prod_s2[31]}}, prod_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_head.command == ics_pkg::CMD_COMPUTE) begin
			item_q <= q_head.item;
			ab_q   <= q_head.ability;
			ncat_q <= ncat_sat;
			ndim_q <= ndim_sat;
			if (!q_head.responded) begin
				for (int i = 0; i < ics_pkg::MAX_CATEGORIES; i++) begin
					ebuf_q[i] <= '0;
				end
			end
		end
		if (state_q == B_EXPW && exp_done) begin
			ebuf_q[k_q] <= exp_res;
		end
		if (state_q == B_DIVST && sum_q == '0) begin
			p_q <= '0;
		end else if (state_q == B_DIVW && div_done) begin
			p_q <= div_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			k_q     <= '0;
			j_q     <= '0;
			sum_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (issue) j_q <= j_q + 1'b1;
			unique case (state_q)
				B_IDLE: begin
					if (take && q_head.command == ics_pkg::CMD_COMPUTE) begin
						k_q     <= '0;
						j_q     <= '0;
						sum_q   <= '0;
						state_q <= q_head.responded ? B_MAC : B_DIVST;
					end
				end
				B_MAC: begin
					if (v_s2 && last_s2) state_q <= B_EXPST;
				end
				B_EXPST: state_q <= B_EXPW;
				B_EXPW: begin
					if (exp_done) begin
						sum_q <= sum_q + ics_pkg::SUM_W'(exp_res);
						j_q   <= '0;
						if (k_q == last_k) begin
							k_q     <= '0;
							state_q <= B_DIVST;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= B_MAC;
						end
					end
				end
				B_DIVST: state_q <= (sum_q == '0) ? B_EMIT : B_DIVW;
				B_DIVW: begin
					if (div_done) state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (k_q == last_k) begin
						state_q <= B_IDLE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= B_DIVST;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	ics_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (exp_go),
		.x      (acc_q),
		.done   (exp_done),
		.result (exp_res)
	);

	ics_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (sum_q),
		.done   (div_done),
		.quot   (div_q)
	);

endmodule

>>> hdl/irt_category_softmax.sv
// -----------------------------------------------------------------------------
// irt_category_softmax
// Multinomial logit item response unit: coefficient loads and per-category
// exp / probability results.
// -----------------------------------------------------------------------------
// Channel   Direction  Handshake                     Payload
// request   in         start & !busy                 command, indexes, coef, abilities
// config    in         cfg_valid & cfg_ready         cfg_index, cfg_data
// result    out        result_valid (one cycle)      category, exp_value, probability, last
//
// A compute request runs the dot products and the exp unit for each
// category (13 serial series terms, each through the multiply, reciprocal
// and accumulate states), then the serial divider, one result strobe per
// category. A request for an unanswered item skips the exp unit and the
// divider.
// Reset clears control state only; the coefficient stores hold no reset value.
// The front queue holds two requests; busy rises while it is full. Results
// cannot be held off by the receiver.
// -----------------------------------------------------------------------------
module irt_category_softmax (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         command,
	input  logic [ics_pkg::ITEM_W-1:0]         item_index,
	input  logic [ics_pkg::CAT_W-1:0]          category_index,
	input  logic [ics_pkg::DIM_W-1:0]          dim_index,
	input  logic signed [ics_pkg::COEF_W-1:0]  coef_value,
	input  logic signed [ics_pkg::COEF_W-1:0]  ability_0,
	input  logic signed [ics_pkg::COEF_W-1:0]  ability_1,
	input  logic signed [ics_pkg::COEF_W-1:0]  ability_2,
	input  logic signed [ics_pkg::COEF_W-1:0]  ability_3,
	input  logic                               responded,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [ics_pkg::NCAT_W-1:0]         cfg_data,
	output logic                               result_valid,
	output logic [ics_pkg::CAT_W-1:0]          category,
	output logic [ics_pkg::EXP_W-1:0]          exp_value,
	output logic [ics_pkg::PROB_W-1:0]         probability,
	output logic                               last
);

	ics_pkg::cmd_t  cmd_in;
	ics_pkg::cmd_t  q_head;
	ics_pkg::cfg_t  cfg_q;
	logic           q_valid;
	logic           q_pop;

	// pack the request fields for the queue
	always_comb begin
		cmd_in.command   = command;
		cmd_in.item      = item_index;
		cmd_in.cat       = category_index;
		cmd_in.dim       = dim_index;
		cmd_in.coef      = coef_value;
		cmd_in.ability   = {ability_3, ability_2, ability_1, ability_0};
		cmd_in.responded = responded;
	end

	// configuration is taken every cycle; users must write only while idle (not enforced)
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ncat <= ics_pkg::NCAT_W'(ics_pkg::MAX_CATEGORIES);
			cfg_q.ndim <= ics_pkg::NDIM_W'(ics_pkg::MAX_DIMS);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ics_pkg::REG_CATS: cfg_q.ncat <= cfg_data;
				ics_pkg::REG_DIMS: cfg_q.ndim <= cfg_data[ics_pkg::NDIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// front: accept, drop unknown commands, queue
	ics_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd_in  (cmd_in),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop)
	);

	// back: stores, dot product, exp, normalization, result strobes
	ics_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.category     (category),
		.exp_value    (exp_value),
		.probability  (probability),
		.last         (last)
	);

endmodule

>>> hdl/ics_checker.sv
// -----------------------------------------------------------------------------
// ics_checker
// Port-level checks of the result stream, bound to the top level.
// -----------------------------------------------------------------------------
module ics_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          result_valid,
	input  logic [ics_pkg::EXP_W-1:0]     exp_value,
	input  logic [ics_pkg::PROB_W-1:0]    probability,
	input  logic                          last
);

	// a probability never exceeds one
	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> probability <= 17'd65536)
		else $error("probability above one");

	// a zero exp value always normalizes to zero
	a_zero_exp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && exp_value == '0 |-> probability == '0)
		else $error("nonzero probability for zero exp");

	// results of a run never come back to back
	a_gap_mid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> !result_valid)
		else $error("back-to-back results inside a run");

	// the final result of a run is followed by a quiet cycle
	a_gap_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid)
		else $error("result right after the final one");

endmodule

bind irt_category_softmax ics_checker u_ics_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.exp_value    (exp_value),
	.probability  (probability),
	.last         (last)
);

>>> verif/irt_category_softmax_tb.sv
// -----------------------------------------------------------------------------
// irt_category_softmax_tb
// Self-checking bench for the category softmax unit. It loads slope and offset
// tables, sends compute requests under several category/dimension settings and
// checks each per-category result against a cycle-free predictor of the
// exp / probability datapath.
// -----------------------------------------------------------------------------
module irt_category_softmax_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [ics_pkg::CAT_W-1:0]  cat;
		logic [ics_pkg::EXP_W-1:0]  ev;
		logic [ics_pkg::PROB_W-1:0] prob;
		logic                       fin;
	} cat_result_t;

	// Predictor and expected-result store. It keeps its own copy of the
	// tables and registers and tracks which table entries have been loaded.
	class softmax_scoreboard;
		logic [15:0]  slope_mem[ics_pkg::SLOPE_DEPTH];
		logic [15:0]  offset_mem[ics_pkg::OFF_DEPTH];
		bit           slope_set[ics_pkg::SLOPE_DEPTH];
		bit           offset_set[ics_pkg::OFF_DEPTH];
		logic [3:0]   ncat_reg = 4'd8;
		logic [2:0]   ndim_reg = 3'd4;
		cat_result_t  expected[$];
		int           errors = 0;

		function void set_reg(logic idx, logic [ics_pkg::NCAT_W-1:0] val);
			if (idx == ics_pkg::REG_CATS)
				ncat_reg = val;
			else
				ndim_reg = val[2:0];
		endfunction

		function bit item_loaded(int it);
			for (int c = 0; c < ics_pkg::MAX_CATEGORIES; c++) begin
				if (!offset_set[it * ics_pkg::MAX_CATEGORIES + c])
					return 0;
				for (int d = 0; d < ics_pkg::MAX_DIMS; d++)
					if (!slope_set[(it * ics_pkg::MAX_CATEGORIES + c) * ics_pkg::MAX_DIMS + d])
						return 0;
			end
			return 1;
		endfunction

		// exp of a Q11.24 predictor as saturating Q16.16, series in Q.30
		function logic [31:0] exp_q16(longint x);
			longint y, n, s;
			longint unsigned f, g, e, term, r;
			if (x >= (64'sd12 <<< 24))
				return 32'hFFFF_FFFF;
			if (x <= -(64'sd12 <<< 24))
				return 32'd0;
			y = (x * 64'sd1549082005) >>> 24;
			n = y >>> 30;
			f = y & ((64'd1 << 30) - 1);
			g = (f * 64'd744261118) >> 30;
			e = 64'd1 << 30;
			term = 64'd1 << 30;
			for (int k = 1; k <= 13; k++) begin
				term = ((term * g) >> 30) / k;
				e += term;
			end
			s = n - 14;
			if (s >= 0)
				r = e << s;
			else
				r = (e + (64'd1 << (-s - 1))) >> (-s);
			return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
		endfunction

		function void note_request(ics_pkg::cmd_t r);
			int ncat, ndim, base;
			bit active;
			longint acc;
			longint unsigned total;
			logic [31:0] evs[ics_pkg::MAX_CATEGORIES];
			cat_result_t res;
			case (r.command)
				ics_pkg::CMD_SLOPE: begin
					base = (r.item * ics_pkg::MAX_CATEGORIES + r.cat) * ics_pkg::MAX_DIMS + r.dim;
					slope_mem[base] = r.coef;
					slope_set[base] = 1;
				end
				ics_pkg::CMD_OFFSET: begin
					offset_mem[r.item * ics_pkg::MAX_CATEGORIES + r.cat] = r.coef;
					offset_set[r.item * ics_pkg::MAX_CATEGORIES + r.cat] = 1;
				end
				ics_pkg::CMD_COMPUTE: begin
					// clamp register values into range; zero counts as one
					ncat = (ncat_reg < 1) ? 1 : (ncat_reg > ics_pkg::MAX_CATEGORIES) ?
						ics_pkg::MAX_CATEGORIES : int'(ncat_reg);
					ndim = (ndim_reg < 1) ? 1 : (ndim_reg > ics_pkg::MAX_DIMS) ?
						ics_pkg::MAX_DIMS : int'(ndim_reg);
					active = r.responded;
					total = 0;
					for (int k = 0; k < ncat; k++) begin
						evs[k] = 0;
						if (active) begin
							acc = longint'($signed(offset_mem[r.item * ics_pkg::MAX_CATEGORIES + k]))
								* 4096;
							for (int d = 0; d < ndim; d++)
								acc += longint'($signed(slope_mem[(r.item * ics_pkg::MAX_CATEGORIES + k)
									* ics_pkg::MAX_DIMS + d])) * longint'($signed(r.ability[d]));
							evs[k] = exp_q16(acc);
						end
						total += evs[k];
					end
					for (int k = 0; k < ncat; k++) begin
						res.cat = ics_pkg::CAT_W'(k);
						res.ev = evs[k];
						res.prob = (total == 0) ? '0 :
							ics_pkg::PROB_W'(((64'(evs[k]) << 16) + total / 2) / total);
						res.fin = (k + 1 == ncat);
						expected.push_back(res);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [ics_pkg::CAT_W-1:0] cat,
				logic [ics_pkg::EXP_W-1:0] ev, logic [ics_pkg::PROB_W-1:0] prob, logic fin);
			cat_result_t want;
			if (expected.size() == 0) begin
				$error("unexpected result: category %0d exp %0h", cat, ev);
				errors++;
				return;
			end
			want = expected.pop_front();
			if (cat !== want.cat) begin
				$error("category: expected %0d, got %0d", want.cat, cat);
				errors++;
			end
			if (ev !== want.ev) begin
				$error("exp_value: expected %0h, got %0h", want.ev, ev);
				errors++;
			end
			if (prob !== want.prob) begin
				$error("probability: expected %0d, got %0d", want.prob, prob);
				errors++;
			end
			if (fin !== want.fin) begin
				$error("last: expected %0b, got %0b", want.fin, fin);
				errors++;
			end
		endfunction
	endclass

	logic                              clk = 0;
	logic                              arst_n = 0;
	logic                              start = 0;
	logic                              busy;
	logic [1:0]                        command = '0;
	logic [ics_pkg::ITEM_W-1:0]        item_index = '0;
	logic [ics_pkg::CAT_W-1:0]         category_index = '0;
	logic [ics_pkg::DIM_W-1:0]         dim_index = '0;
	logic signed [ics_pkg::COEF_W-1:0] coef_value = '0;
	logic signed [ics_pkg::COEF_W-1:0] ability_0 = '0;
	logic signed [ics_pkg::COEF_W-1:0] ability_1 = '0;
	logic signed [ics_pkg::COEF_W-1:0] ability_2 = '0;
	logic signed [ics_pkg::COEF_W-1:0] ability_3 = '0;
	logic                              responded = 0;
	logic                              cfg_valid = 0;
	logic                              cfg_ready;
	logic                              cfg_index = 0;
	logic [ics_pkg::NCAT_W-1:0]        cfg_data = '0;
	logic                              result_valid;
	logic [ics_pkg::CAT_W-1:0]         category;
	logic [ics_pkg::EXP_W-1:0]         exp_value;
	logic [ics_pkg::PROB_W-1:0]        probability;
	logic                              last;

	softmax_scoreboard sb = new();
	bit idle_on = 1;
	int pool[$];

	irt_category_softmax u_top (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Results cannot be stalled: sample every strobe at the edge that ends it.
	always @(posedge clk)
		if (arst_n && result_valid)
			sb.check_result(category, exp_value, probability, last);

	// Drop start for a random gap about 31 times in a hundred.
	task automatic maybe_idle();
		if (idle_on && $urandom_range(0, 99) < 31) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Present one request and hold it until the block takes it.
	task automatic send(ics_pkg::cmd_t r);
		maybe_idle();
		start <= 1;
		command <= r.command;
		item_index <= r.item;
		category_index <= r.cat;
		dim_index <= r.dim;
		coef_value <= r.coef;
		ability_0 <= r.ability[0];
		ability_1 <= r.ability[1];
		ability_2 <= r.ability[2];
		ability_3 <= r.ability[3];
		responded <= r.responded;
		do @(posedge clk); while (busy);
		sb.note_request(r);
	endtask

	// Wait for every expected result, then let trailing loads drain.
	task automatic settle();
		start <= 0;
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [ics_pkg::NCAT_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// Mix of full-range, small, extreme and near-zero coefficients.
	function automatic logic [15:0] pick_coef();
		case ($urandom_range(0, 5))
			0, 1: return 16'($urandom());
			2, 3: return 16'($signed($urandom_range(0, 4095)) - 2048);
			4:    return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'($signed($urandom_range(0, 31)) - 16);
		endcase
	endfunction

	function automatic ics_pkg::cmd_t make_req(ics_pkg::command_t op, int it, int cat, int dim,
			logic [15:0] coef, logic resp);
		ics_pkg::cmd_t r;
		r.command = op;
		r.item = ics_pkg::ITEM_W'(it);
		r.cat = ics_pkg::CAT_W'(cat);
		r.dim = ics_pkg::DIM_W'(dim);
		r.coef = coef;
		for (int d = 0; d < 4; d++)
			r.ability[d] = pick_coef();
		r.responded = resp;
		return r;
	endfunction

	// Load every slope and offset of one item: a full well-formed table set.
	task automatic load_item(int it);
		for (int c = 0; c < ics_pkg::MAX_CATEGORIES; c++) begin
			send(make_req(ics_pkg::CMD_OFFSET, it, c, $urandom_range(0, 3), pick_coef(), 1'b0));
			for (int d = 0; d < ics_pkg::MAX_DIMS; d++)
				send(make_req(ics_pkg::CMD_SLOPE, it, c, d, pick_coef(),
					1'($urandom_range(0, 1))));
		end
	endtask

	task automatic random_phase(int count);
		ics_pkg::cmd_t r;
		int sel, it;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				it = pool[$urandom_range(0, pool.size() - 1)];
				send(make_req(ics_pkg::CMD_COMPUTE, it, $urandom_range(0, 7),
					$urandom_range(0, 3), 16'($urandom()), $urandom_range(0, 9) != 0));
			end else if (sel < 80) begin
				// rewrite: half to loaded items, half anywhere
				it = $urandom_range(0, 1) ? pool[$urandom_range(0, pool.size() - 1)] :
					$urandom_range(0, ics_pkg::MAX_ITEMS - 1);
				send(make_req($urandom_range(0, 1) ? ics_pkg::CMD_SLOPE : ics_pkg::CMD_OFFSET, it,
					$urandom_range(0, 7), $urandom_range(0, 3), pick_coef(),
					1'($urandom_range(0, 1))));
			end else if (sel < 90) begin
				it = $urandom_range(0, ics_pkg::MAX_ITEMS - 1);
				r = make_req(ics_pkg::CMD_COMPUTE, it, $urandom_range(0, 7), $urandom_range(0, 3),
					16'($urandom()), sb.item_loaded(it) && ($urandom_range(0, 1) == 1));
				send(r);
			end else begin
				send(make_req(ics_pkg::CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 7),
					$urandom_range(0, 3), 16'($urandom()), 1'($urandom_range(0, 1))));
			end
		end
		settle();
	endtask

	initial begin
		ics_pkg::cmd_t r;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: two categories, one dimension, item 0.
		write_reg(ics_pkg::REG_CATS, 4'd2);
		write_reg(ics_pkg::REG_DIMS, 4'd1);
		send(make_req(ics_pkg::CMD_SLOPE, 0, 0, 0, 16'h7FFF, 1'b0));
		send(make_req(ics_pkg::CMD_SLOPE, 0, 1, 0, 16'h8000, 1'b0));
		send(make_req(ics_pkg::CMD_OFFSET, 0, 0, 0, 16'h7FFF, 1'b0));
		send(make_req(ics_pkg::CMD_OFFSET, 0, 1, 0, 16'h8000, 1'b0));
		r = make_req(ics_pkg::CMD_COMPUTE, 0, 0, 0, 16'h0000, 1'b1);
		r.ability[0] = 16'h7FFF;
		send(r);
		r.ability[0] = 16'h8000;
		send(r);
		r.ability[0] = 16'h0000;
		send(r);
		// unanswered item: zeros, categories still walked
		send(make_req(ics_pkg::CMD_COMPUTE, 63, 7, 3, 16'hFFFF, 1'b0));
		// unknown command: no result
		send(make_req(ics_pkg::CMD_NONE, 63, 7, 3, 16'hFFFF, 1'b1));
		send(make_req(ics_pkg::CMD_SLOPE, 63, 7, 3, 16'hFFFF, 1'b1));
		send(make_req(ics_pkg::CMD_OFFSET, 63, 7, 0, 16'h0000, 1'b0));
		// drive both predictors far below -12: zero sum; then both just above -8
		send(make_req(ics_pkg::CMD_OFFSET, 0, 0, 0, 16'h8000, 1'b0));
		send(make_req(ics_pkg::CMD_SLOPE, 0, 1, 0, 16'h7FFF, 1'b0));
		r = make_req(ics_pkg::CMD_COMPUTE, 0, 0, 0, 16'h0000, 1'b1);
		r.ability[0] = 16'h8000;
		send(r);
		r.ability[0] = 16'h0010;
		send(r);
		settle();

		// Well-formed loads of a few items, then random traffic per setting.
		write_reg(ics_pkg::REG_CATS, 4'd8);
		write_reg(ics_pkg::REG_DIMS, 4'd4);
		pool.push_back(0);
		pool.push_back(63);
		pool.push_back($urandom_range(1, 31));
		pool.push_back($urandom_range(32, 62));
		foreach (pool[i])
			load_item(pool[i]);
		random_phase(45);

		// no idling in this stretch
		idle_on = 0;
		write_reg(ics_pkg::REG_CATS, 4'd1);
		write_reg(ics_pkg::REG_DIMS, 4'd1);
		random_phase(45);
		idle_on = 1;

		write_reg(ics_pkg::REG_CATS, 4'd3);
		write_reg(ics_pkg::REG_DIMS, 4'd2);
		random_phase(45);

		// out-of-range register values saturate: zero acts as one
		write_reg(ics_pkg::REG_CATS, 4'd0);
		write_reg(ics_pkg::REG_DIMS, 4'd0);
		random_phase(45);

		write_reg(ics_pkg::REG_CATS, 4'd15);
		write_reg(ics_pkg::REG_DIMS, 4'd15);
		random_phase(45);

		write_reg(ics_pkg::REG_CATS, 4'd5);
		write_reg(ics_pkg::REG_DIMS, 4'd3);
		random_phase(45);

		if (sb.errors == 0)
			$display("irt_category_softmax_tb: clean");
		else
			$display("irt_category_softmax_tb: errors");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("irt_category_softmax_tb: errors");
		$finish;
	end

endmodule

>>> filelist.f
hdl/ics_pkg.sv
hdl/ics_front.sv
hdl/ics_exp.sv
hdl/ics_div.sv
hdl/ics_back.sv
hdl/irt_category_softmax.sv
hdl/ics_checker.sv
verif/irt_category_softmax_tb.sv
